@@ sv/wrs_pkg.sv @@
// Package for the weighted random selector: sizes, derived types, FSM states
// and the total-weight saturation helper.
// No dependencies.
package wrs_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int WEIGHT_BITS = 16;

    localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
    localparam int SUM_BITS   = WEIGHT_BITS + IDX_BITS;
    localparam int TOTAL_BITS = 24;
    localparam int PT_BITS    = 24;
    localparam int CMP_BITS   = (WEIGHT_BITS > PT_BITS) ? WEIGHT_BITS : PT_BITS;
    localparam int EXT_BITS   = (SUM_BITS > TOTAL_BITS) ? SUM_BITS : TOTAL_BITS;
    localparam int CFG_BITS   = 9;

    typedef logic [IDX_BITS-1:0]    idx_t;
    typedef logic [WEIGHT_BITS-1:0] wgt_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [TOTAL_BITS-1:0]  total_t;
    typedef logic [PT_BITS-1:0]     pt_t;
    typedef logic [CMP_BITS-1:0]    cmp_t;
    typedef logic [EXT_BITS-1:0]    ext_t;
    typedef logic [CFG_BITS-1:0]    cfg_t;
    typedef logic [7:0]             chosen_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WR,
        S_SCAN,
        S_DONE
    } state_t;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_DRAW  = 1'b1;

    // Clamp the internal sum to the reported field width.
    function automatic total_t sat_total(input sum_t s);
        ext_t se;
        se = ext_t'(s);
        if (se > ext_t'({TOTAL_BITS{1'b1}}))
            return {TOTAL_BITS{1'b1}};
        return total_t'(se);
    endfunction

endpackage

@@ sv/wrs_ifs.sv @@
// Valid/ready channel interfaces for the weighted random selector:
// request, response and configuration words.
// Depends on wrs_pkg.
interface wrs_req_if;
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [7:0]             entry_index;
    logic [15:0]            weight_value;
    logic [23:0]            draw_point;

    modport source (output valid, action, entry_index, weight_value, draw_point,
                    input ready);
    modport sink   (input valid, action, entry_index, weight_value, draw_point,
                    output ready);
endinterface

interface wrs_rsp_if;
    logic                   valid;
    logic                   ready;
    logic [7:0]             chosen_index;
    logic [23:0]            total_weight;
    logic                   fell_back;

    modport source (output valid, chosen_index, total_weight, fell_back,
                    input ready);
    modport sink   (input valid, chosen_index, total_weight, fell_back,
                    output ready);
endinterface

interface wrs_cfg_if;
    logic                   valid;
    logic                   ready;
    wrs_pkg::cfg_t          data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ sv/weighted_random_selector.sv @@
// Weighted random selector (roulette wheel): weight RAM, running total, linear scan on draw.
// Depends on wrs_pkg and wrs_ifs.
// Sequence: a write passes S_WR (old weight swapped out of the total) and S_DONE to the output;
//   a draw scans k entries (1 .. entries_in_use), one per cycle from the RAM read port.
// Flow: one word in flight; S_DONE waits while the output register is held by rsp stalls.
// Reset: async active-low; total cleared, table reads zero via valid bits, 256 entries in use.
module weighted_random_selector
(
    input  logic          clk,
    input  logic          rst_n,
    wrs_req_if.sink       req,
    wrs_rsp_if.source     rsp,
    wrs_cfg_if.sink       cfg
);

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    wrs_pkg::state_t  state_reg, state_next;
    wrs_pkg::cfg_t    entries_reg;
    wrs_pkg::sum_t    sum_reg, sum_next;
    wrs_pkg::idx_t    idx_reg, idx_next;         // write target / scan position
    wrs_pkg::wgt_t    wval_reg, wval_next;
    logic             wr_ok_reg, wr_ok_next;     // write target inside the table
    wrs_pkg::pt_t     point_reg, point_next;     // remaining draw point

    // Result held until the output register is free
    wrs_pkg::chosen_t res_chosen_reg, res_chosen_next;
    logic             res_fell_reg, res_fell_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    wrs_pkg::chosen_t out_chosen_reg, out_chosen_next;
    wrs_pkg::total_t  out_total_reg, out_total_next;
    logic             out_fell_reg, out_fell_next;

    // ------------------------------------------------------------------
    // Weight RAM: one write and one registered read port. Per-entry valid
    // bits stand in for the all-zero reset contents.
    // ------------------------------------------------------------------
    wrs_pkg::wgt_t                      wmem [wrs_pkg::MAX_ENTRIES];
    logic [wrs_pkg::MAX_ENTRIES-1:0]    vld_reg;
    wrs_pkg::wgt_t                      rdata_reg;
    logic                               rvld_reg;
    wrs_pkg::idx_t                      raddr;
    logic                               mem_we;
    wrs_pkg::wgt_t                      w_eff;

    assign w_eff = rvld_reg ? rdata_reg : '0;

    always_ff @(posedge clk)
    begin
        rdata_reg <= wmem[raddr];
        if (mem_we)
        begin
            wmem[idx_reg] <= wval_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            rvld_reg <= vld_reg[raddr];
            if (mem_we)
            begin
                vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration: always ready, only written while idle by contract
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= wrs_pkg::cfg_t'(256);
        end
        else if (cfg.valid)
        begin
            entries_reg <= cfg.data;
        end
    end

    // Last scanned entry: zero acts as one, above the table acts as full
    wrs_pkg::idx_t last_idx;

    always_comb
    begin
        if (entries_reg == '0)
            last_idx = '0;
        else if (32'(entries_reg) > wrs_pkg::MAX_ENTRIES)
            last_idx = wrs_pkg::idx_t'(wrs_pkg::MAX_ENTRIES - 1);
        else
            last_idx = wrs_pkg::idx_t'(entries_reg - wrs_pkg::cfg_t'(1));
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic          req_acc;
    logic          out_free;
    logic          hit;
    wrs_pkg::cmp_t point_ext;
    wrs_pkg::cmp_t w_ext;

    assign req.ready = (state_reg == wrs_pkg::S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign point_ext = wrs_pkg::cmp_t'(point_reg);
    assign w_ext     = wrs_pkg::cmp_t'(w_eff);
    assign hit       = point_ext < w_ext;

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        idx_next        = idx_reg;
        wval_next       = wval_reg;
        wr_ok_next      = wr_ok_reg;
        point_next      = point_reg;
        res_chosen_next = res_chosen_reg;
        res_fell_next   = res_fell_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_chosen_next = out_chosen_reg;
        out_total_next  = out_total_reg;
        out_fell_next   = out_fell_reg;
        raddr           = idx_reg + wrs_pkg::idx_t'(1);   // scan prefetch
        mem_we          = 1'b0;

        case (state_reg)
            wrs_pkg::S_IDLE:
            begin
                if (req.action == wrs_pkg::ACT_WRITE)
                    raddr = wrs_pkg::idx_t'(req.entry_index);
                else
                    raddr = '0;
                if (req_acc)
                begin
                    wval_next  = wrs_pkg::wgt_t'(req.weight_value);
                    point_next = req.draw_point;
                    wr_ok_next = 32'(req.entry_index) < wrs_pkg::MAX_ENTRIES;
                    if (req.action == wrs_pkg::ACT_WRITE)
                    begin
                        idx_next   = wrs_pkg::idx_t'(req.entry_index);
                        state_next = wrs_pkg::S_WR;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = wrs_pkg::S_SCAN;
                    end
                end
            end

            // Old weight has arrived: swap it out of the total, write back
            wrs_pkg::S_WR:
            begin
                if (wr_ok_reg)
                begin
                    mem_we   = 1'b1;
                    sum_next = sum_reg - wrs_pkg::sum_t'(w_eff)
                                       + wrs_pkg::sum_t'(wval_reg);
                end
                res_chosen_next = '0;
                res_fell_next   = 1'b0;
                state_next      = wrs_pkg::S_DONE;
            end

            // One entry per cycle; next address already issued
            wrs_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    res_chosen_next = wrs_pkg::chosen_t'(idx_reg);
                    res_fell_next   = 1'b0;
                    state_next      = wrs_pkg::S_DONE;
                end
                else if (idx_reg == last_idx)
                begin
                    res_chosen_next = wrs_pkg::chosen_t'(last_idx);
                    res_fell_next   = 1'b1;
                    state_next      = wrs_pkg::S_DONE;
                end
                else
                begin
                    point_next = wrs_pkg::pt_t'(point_ext - w_ext);
                    idx_next   = idx_reg + wrs_pkg::idx_t'(1);
                end
            end

            wrs_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_chosen_next = res_chosen_reg;
                    out_total_next  = wrs_pkg::sat_total(sum_reg);
                    out_fell_next   = res_fell_reg;
                    state_next      = wrs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrs_pkg::S_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        wval_reg       <= wval_next;
        wr_ok_reg      <= wr_ok_next;
        point_reg      <= point_next;
        res_chosen_reg <= res_chosen_next;
        res_fell_reg   <= res_fell_next;
        out_chosen_reg <= out_chosen_next;
        out_total_reg  <= out_total_next;
        out_fell_reg   <= out_fell_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.chosen_index = out_chosen_reg;
    assign rsp.total_weight = out_total_reg;
    assign rsp.fell_back    = out_fell_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wrs_pkg::S_SCAN |-> idx_reg <= last_idx)
        else $error("scan ran past last entry in use");

    a_wr_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> vld_reg[$past(idx_reg)])
        else $error("written entry not marked valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_total_reg))
        else $error("pending result overwritten");

    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wrs_pkg::S_DONE && out_free |=> out_valid_reg)
        else $error("result not loaded into output register");

endmodule
